// ----- rtl/pltg_pkg.sv -----
// Shared types and constants of the piecewise linear trace gain block.
`default_nettype none
package pltg_pkg;

   localparam int MAX_KNEES   = 8;
   localparam int MAX_SAMPLES = 65536;
   localparam int KNEE_AW     = $clog2(MAX_KNEES);
   localparam int IDX_W       = $clog2(MAX_SAMPLES);
   localparam int NK_W        = 4;
   localparam int POS_W       = 24;
   localparam int DAT_W       = 32;

   // register indexes
   localparam logic [1:0] REG_NUM_KNEES    = 2'd0;
   localparam logic [1:0] REG_WINDOW_START = 2'd1;
   localparam logic [1:0] REG_WINDOW_END   = 2'd2;
   localparam logic [1:0] REG_GAIN_SOURCE  = 2'd3;

   // request kinds
   localparam logic FUNC_LOAD   = 1'b0;
   localparam logic FUNC_SAMPLE = 1'b1;

   localparam logic SRC_KNEES = 1'b0;
   localparam logic SRC_TRACE = 1'b1;

   typedef struct packed {
      logic [IDX_W-1:0] window_start;
      logic [IDX_W-1:0] window_end;
   } win_cfg_type;

   typedef struct packed {
      logic [NK_W-1:0] num_knees;
      logic            gain_source;
   } gain_cfg_type;

   typedef struct packed {
      logic                    is_load;
      logic [KNEE_AW-1:0]      slot;
      logic [POS_W-1:0]        pos;
      logic signed [DAT_W-1:0] kgain;
      logic signed [DAT_W-1:0] sample;
      logic signed [DAT_W-1:0] tgain;
      logic                    tend;
      logic [IDX_W-1:0]        idx;
      logic                    scale;
      logic                    seg_clear;
   } item_type;

endpackage
`default_nettype wire

// ----- rtl/pltg_if.sv -----
// Request and response channel interfaces.
`default_nettype none
interface pltg_req_if;
   logic               valid;
   logic               ready;
   logic               func;
   logic [2:0]         knee_slot;
   logic [23:0]        knee_position;
   logic signed [31:0] knee_gain;
   logic signed [31:0] sample_in;
   logic signed [31:0] trace_gain;
   logic               trace_end;
   modport source (output valid, func, knee_slot, knee_position, knee_gain, sample_in,
                   trace_gain, trace_end, input ready);
   modport sink (input valid, func, knee_slot, knee_position, knee_gain, sample_in,
                 trace_gain, trace_end, output ready);
endinterface

interface pltg_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] sample_out;
   logic               out_trace_end;
   modport source (output valid, sample_out, out_trace_end, input ready);
   modport sink (input valid, sample_out, out_trace_end, output ready);
endinterface
`default_nettype wire

// ----- rtl/pltg_ram.sv -----
// Generic single write, single read RAM with registered read data.
`default_nettype none
module pltg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write and read one entry each cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

// ----- rtl/pltg_front.sv -----
// Front end: accepts requests, tracks the sample index and classifies each request.
`default_nettype none
module pltg_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   pltg_req_if.sink                   req_ch,
   input  wire pltg_pkg::win_cfg_type win_cfg,
   input  wire logic                  q_full,
   output logic                       q_push,
   output pltg_pkg::item_type         q_item
);
   logic [pltg_pkg::IDX_W-1:0] count_ff, count_in;
   logic                       in_win;

   assign req_ch.ready = !q_full;
   assign q_push = req_ch.valid && req_ch.ready;

   // classify the request against the window
   always_comb begin
      in_win = (win_cfg.window_start <= win_cfg.window_end)
            && (count_ff >= win_cfg.window_start) && (count_ff <= win_cfg.window_end);
      q_item.is_load   = (req_ch.func == pltg_pkg::FUNC_LOAD);
      q_item.slot      = req_ch.knee_slot;
      q_item.pos       = req_ch.knee_position;
      q_item.kgain     = req_ch.knee_gain;
      q_item.sample    = req_ch.sample_in;
      q_item.tgain     = req_ch.trace_gain;
      q_item.tend      = req_ch.trace_end;
      q_item.idx       = count_ff;
      q_item.scale     = in_win;
      q_item.seg_clear = req_ch.trace_end || (count_ff == {pltg_pkg::IDX_W{1'b1}});
   end

   // advance the index on each sample, restart after trace end or wrap
   always_comb begin
      count_in = count_ff;
      if (q_push && !q_item.is_load) begin
         count_in = q_item.seg_clear ? '0 : count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end
endmodule
`default_nettype wire

// ----- rtl/pltg_queue.sv -----
// Two-entry queue between front and back end.
`default_nettype none
module pltg_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire pltg_pkg::item_type push_item,
   output logic                    full,
   input  wire logic               pop,
   output logic                    not_empty,
   output pltg_pkg::item_type      head
);
   pltg_pkg::item_type entry_ff [2];
   logic               wr_ptr_ff, rd_ptr_ff;
   logic [1:0]         count_ff;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = entry_ff[rd_ptr_ff];

   // store on push
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   // advance pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop) rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule
`default_nettype wire

// ----- rtl/pltg_back.sv -----
// Back end: knee table, segment search, serial weight division, gain and output.
`default_nettype none
module pltg_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire pltg_pkg::gain_cfg_type gain_cfg,
   input  wire logic                   q_not_empty,
   input  wire pltg_pkg::item_type     q_head,
   output logic                        q_pop,
   pltg_rsp_if.source                  rsp_ch
);
   localparam int KA = pltg_pkg::KNEE_AW;
   localparam int PW = pltg_pkg::POS_W;
   localparam int DW = pltg_pkg::DAT_W;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_RD0    = 4'd1;
   localparam logic [3:0] S_RDL    = 4'd2;
   localparam logic [3:0] S_SEG    = 4'd3;
   localparam logic [3:0] S_LOW    = 4'd4;
   localparam logic [3:0] S_DIV    = 4'd5;
   localparam logic [3:0] S_INTERP = 4'd6;
   localparam logic [3:0] S_GADD   = 4'd7;
   localparam logic [3:0] S_MUL    = 4'd8;
   localparam logic [3:0] S_SAT    = 4'd9;
   localparam logic [3:0] S_OUT    = 4'd10;

   logic [3:0]               state_ff, state_in;
   pltg_pkg::item_type       item_ff, item_in;
   logic [KA-1:0]            seg_ff, seg_in;
   logic [PW-1:0]            pa_ff, pa_in, pb_ff, pb_in;
   logic signed [DW-1:0]     ga_ff, ga_in, gb_ff, gb_in, gain_ff, gain_in;
   logic [PW:0]              rem_ff, rem_in;
   logic [PW-1:0]            norm_ff, norm_in;
   logic [15:0]              q_ff, q_in;
   logic [3:0]               cnt_ff, cnt_in;
   logic [16:0]              w_ff, w_in;
   logic signed [50:0]       prod_ff, prod_in;
   logic signed [63:0]       mul_ff, mul_in;
   logic signed [DW-1:0]     res_ff, res_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DW-1:0]     out_data_ff, out_data_in;
   logic                     out_tend_ff, out_tend_in;

   logic [KA-1:0]            rd_addr;
   logic [PW+DW-1:0]         rd_data;
   logic [PW-1:0]            rd_pos;
   logic signed [DW-1:0]     rd_gain;
   logic [pltg_pkg::NK_W-1:0] n_eff;
   logic [KA-1:0]            n_last;
   logic [KA-1:0]            seg_c;
   logic [PW-1:0]            iq;
   logic [16:0]              first_idx, last_idx, idx_ext;
   logic [PW:0]              pl_sum;
   logic [PW:0]              rem2;
   logic signed [32:0]       gdiff;
   logic signed [47:0]       yq;
   logic                     out_free;

   pltg_ram #(.WIDTH(PW + DW), .DEPTH(pltg_pkg::MAX_KNEES)) u_knee_ram (
      .clock   (clock),
      .wr_en   (q_pop && q_head.is_load),
      .wr_addr (q_head.slot),
      .wr_data ({q_head.pos, q_head.kgain}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_pos  = rd_data[PW+DW-1:DW];
   assign rd_gain = rd_data[DW-1:0];

   assign q_pop         = (state_ff == S_IDLE) && q_not_empty;
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.sample_out    = out_data_ff;
   assign rsp_ch.out_trace_end = out_tend_ff;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   // clamp the knee count and derive boundary indexes
   always_comb begin
      if (gain_cfg.num_knees == '0) begin
         n_eff = pltg_pkg::NK_W'(1);
      end else if (int'(gain_cfg.num_knees) > pltg_pkg::MAX_KNEES) begin
         n_eff = pltg_pkg::NK_W'(pltg_pkg::MAX_KNEES);
      end else begin
         n_eff = gain_cfg.num_knees;
      end
      n_last = KA'(n_eff - 1'b1);
      if (seg_ff == '0) begin
         seg_c = KA'(1);
      end else if (seg_ff > n_last) begin
         seg_c = n_last;
      end else begin
         seg_c = seg_ff;
      end
      iq        = {item_ff.idx, 8'h00};
      idx_ext   = {1'b0, item_ff.idx};
      first_idx = {1'b0, pa_ff[PW-1:8]} + 17'd1;
      pl_sum    = {1'b0, rd_pos} + 25'd2;
      last_idx  = pl_sum[PW:8];
      rem2      = {rem_ff[PW-1:0], 1'b0};
      gdiff     = {gb_ff[DW-1], gb_ff} - {ga_ff[DW-1], ga_ff};
      yq        = mul_ff[63] ? 48'((mul_ff + 64'sd65535) >>> 16) : 48'(mul_ff >>> 16);
   end

   // sequence one request through the back end
   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      seg_in       = seg_ff;
      pa_in        = pa_ff;
      pb_in        = pb_ff;
      ga_in        = ga_ff;
      gb_in        = gb_ff;
      gain_in      = gain_ff;
      rem_in       = rem_ff;
      norm_in      = norm_ff;
      q_in         = q_ff;
      cnt_in       = cnt_ff;
      w_in         = w_ff;
      prod_in      = prod_ff;
      mul_in       = mul_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      out_data_in  = out_data_ff;
      out_tend_in  = out_tend_ff;
      rd_addr      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (q_not_empty) begin
               item_in = q_head;
               if (q_head.is_load) begin
                  state_in = S_IDLE;
               end else if (!q_head.scale) begin
                  res_in   = q_head.sample;
                  state_in = S_OUT;
               end else if (gain_cfg.gain_source == pltg_pkg::SRC_TRACE) begin
                  gain_in  = q_head.tgain;
                  state_in = S_MUL;
               end else begin
                  state_in = S_RD0;
               end
            end
         end
         S_RD0: begin
            pa_in = rd_pos;
            ga_in = rd_gain;
            if (n_eff == pltg_pkg::NK_W'(1)) begin
               gain_in  = rd_gain;
               state_in = S_MUL;
            end else begin
               rd_addr  = n_last;
               state_in = S_RDL;
            end
         end
         S_RDL: begin
            if (idx_ext < first_idx) begin
               gain_in  = ga_ff;
               state_in = S_MUL;
            end else if (idx_ext >= last_idx) begin
               gain_in  = rd_gain;
               state_in = S_MUL;
            end else begin
               seg_in   = seg_c;
               rd_addr  = seg_c;
               state_in = S_SEG;
            end
         end
         S_SEG: begin
            if (seg_ff < n_last && iq > rd_pos) begin
               seg_in  = seg_ff + 1'b1;
               rd_addr = seg_ff + 1'b1;
            end else begin
               pb_in    = rd_pos;
               gb_in    = rd_gain;
               rd_addr  = seg_ff - 1'b1;
               state_in = S_LOW;
            end
         end
         S_LOW: begin
            pa_in   = rd_pos;
            ga_in   = rd_gain;
            norm_in = pb_ff - rd_pos;
            rem_in  = {1'b0, iq - rd_pos};
            cnt_in  = '0;
            if (pb_ff <= rd_pos) begin
               gain_in  = gb_ff;
               state_in = S_MUL;
            end else if (iq <= rd_pos) begin
               w_in     = '0;
               state_in = S_INTERP;
            end else if ((iq - rd_pos) >= (pb_ff - rd_pos)) begin
               w_in     = 17'h10000;
               state_in = S_INTERP;
            end else begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            // one restoring quotient bit per cycle
            if (rem2 >= {1'b0, norm_ff}) begin
               rem_in = rem2 - {1'b0, norm_ff};
               q_in   = {q_ff[14:0], 1'b1};
            end else begin
               rem_in = rem2;
               q_in   = {q_ff[14:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 4'd15) begin
               w_in     = {1'b0, q_in};
               state_in = S_INTERP;
            end
         end
         S_INTERP: begin
            prod_in  = 51'(gdiff) * 51'($signed({1'b0, w_ff}));
            state_in = S_GADD;
         end
         S_GADD: begin
            gain_in  = ga_ff + DW'(prod_ff >>> 16);
            state_in = S_MUL;
         end
         S_MUL: begin
            mul_in   = item_ff.sample * gain_ff;
            state_in = S_SAT;
         end
         S_SAT: begin
            if (yq > 48'sh0000_7FFF_FFFF) begin
               res_in = 32'sh7FFF_FFFF;
            end else if (yq < -48'sh0000_8000_0000) begin
               res_in = -32'sh8000_0000;
            end else begin
               res_in = yq[DW-1:0];
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_data_in  = res_ff;
               out_tend_in  = item_ff.tend;
               if (item_ff.seg_clear) begin
                  seg_in = KA'(1);
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         seg_ff       <= KA'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seg_ff       <= seg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      pa_ff       <= pa_in;
      pb_ff       <= pb_in;
      ga_ff       <= ga_in;
      gb_ff       <= gb_in;
      gain_ff     <= gain_in;
      rem_ff      <= rem_in;
      norm_ff     <= norm_in;
      q_ff        <= q_in;
      cnt_ff      <= cnt_in;
      w_ff        <= w_in;
      prod_ff     <= prod_in;
      mul_ff      <= mul_in;
      res_ff      <= res_in;
      out_data_ff <= out_data_in;
      out_tend_ff <= out_tend_in;
   end

   a_seg_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEG) |-> (seg_ff >= KA'(1) && seg_ff <= n_last))
      else $error("segment index out of range");
   a_weight_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INTERP) |-> (w_ff <= 17'h10000))
      else $error("weight above one");
   a_out_return: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && out_free) |=> (state_ff == S_IDLE && rsp_valid_ff))
      else $error("response not issued");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == S_IDLE))
      else $error("pop while busy");
endmodule
`default_nettype wire

// ----- rtl/piecewise_linear_trace_gain_core.sv -----
// Top level of the piecewise linear trace gain block with its register port.
// Scales each trace sample by a Q16.16 gain inside an index window; the gain comes from
// the per-trace field or from linear interpolation over up to eight knees. The back end
// takes one request at a time: a knee load only writes the knee RAM, an unscaled sample
// goes straight to the output, and an interior sample also reads its segment knees one
// by one through the single read port of the knee RAM and, unless the span is zero or
// the weight clamps, runs the serial weight divider. A stalled response holds the back
// end, and a two-entry queue lets requests be taken while the back end works.
`default_nettype none
module piecewise_linear_trace_gain_core (
   input  wire logic        clock,
   input  wire logic        reset,
   pltg_req_if.sink         req_ch,
   pltg_rsp_if.source       rsp_ch,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   logic [pltg_pkg::NK_W-1:0]  num_knees_ff;
   logic [pltg_pkg::IDX_W-1:0] window_start_ff, window_end_ff;
   logic                       gain_source_ff;
   logic                       wr_en;
   pltg_pkg::win_cfg_type      win_cfg;
   pltg_pkg::gain_cfg_type     gain_cfg;
   logic                       q_full, q_push, q_pop, q_not_empty;
   pltg_pkg::item_type         q_item, q_head;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         num_knees_ff    <= pltg_pkg::NK_W'(1);
         window_start_ff <= '0;
         window_end_ff   <= '1;
         gain_source_ff  <= pltg_pkg::SRC_KNEES;
      end else if (wr_en) begin
         unique case (csr_paddr[3:2])
            pltg_pkg::REG_NUM_KNEES:    num_knees_ff    <= csr_pwdata[pltg_pkg::NK_W-1:0];
            pltg_pkg::REG_WINDOW_START: window_start_ff <= csr_pwdata[pltg_pkg::IDX_W-1:0];
            pltg_pkg::REG_WINDOW_END:   window_end_ff   <= csr_pwdata[pltg_pkg::IDX_W-1:0];
            pltg_pkg::REG_GAIN_SOURCE:  gain_source_ff  <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   // read back
   always_comb begin
      unique case (csr_paddr[3:2])
         pltg_pkg::REG_NUM_KNEES:    csr_prdata = 32'(num_knees_ff);
         pltg_pkg::REG_WINDOW_START: csr_prdata = 32'(window_start_ff);
         pltg_pkg::REG_WINDOW_END:   csr_prdata = 32'(window_end_ff);
         pltg_pkg::REG_GAIN_SOURCE:  csr_prdata = 32'(gain_source_ff);
         default:                    csr_prdata = '0;
      endcase
   end

   assign win_cfg.window_start = window_start_ff;
   assign win_cfg.window_end   = window_end_ff;
   assign gain_cfg.num_knees   = num_knees_ff;
   assign gain_cfg.gain_source = gain_source_ff;

   pltg_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .win_cfg (win_cfg),
      .q_full  (q_full),
      .q_push  (q_push),
      .q_item  (q_item)
   );

   pltg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_item),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   pltg_back u_back (
      .clock       (clock),
      .reset       (reset),
      .gain_cfg    (gain_cfg),
      .q_not_empty (q_not_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp_ch      (rsp_ch)
   );
endmodule
`default_nettype wire
